>>> sv/mwa_pkg.sv
// Package for the max-weight assignment unit: sequencer states and the
// result record passed from the solver to the top level. No dependencies.
package mwa_pkg;

  localparam int COL_W   = 6;
  localparam int ROW_W   = 6;
  localparam int PAIR_W  = 16;
  localparam int TOTAL_W = 22;
  localparam int CFG_W   = 7;
  localparam int POS_W   = 12;
  localparam logic [POS_W-1:0] POS_MAX = 12'd4095;

  typedef enum logic [3:0] {
    S_IDLE,   // waiting for a loaded matrix
    S_INIT,   // row maxima scan
    S_TRY,    // start a search from the current root row
    S_DFS,    // pop or expand the top of the search stack
    S_CHK,    // test one edge against the labels
    S_BACK,   // flip matches along the stacked path
    S_NEXT,   // advance to the next root row
    S_DELTA,  // minimum slack scan
    S_ADJ,    // apply the slack to the labels
    S_ORD,    // read the weight of one result
    S_OLD     // hand one result to the output register
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [PAIR_W-1:0]  pair;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } res_t;

endpackage

>>> sv/mwa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module mwa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/mwa_ctrl.sv
// Kuhn-Munkres solver sequencer: labels, matches, search stack, slack scan
// and result generation. Reads weights through the RAM read port.
// Depends on mwa_pkg.
module mwa_ctrl #(
  parameter int MAX_SIZE    = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [$clog2(MAX_SIZE+1)-1:0]       n,
  output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] rd_addr,
  input  logic [WEIGHT_BITS-1:0]              rd_data,
  input  logic                                res_free,
  output mwa_pkg::res_t                       res
);
  import mwa_pkg::*;

  localparam int IW  = $clog2(MAX_SIZE);
  localparam int NW  = $clog2(MAX_SIZE+1);
  localparam int AW  = $clog2(MAX_SIZE*MAX_SIZE);
  localparam int LW  = (WEIGHT_BITS + 8 > 24) ? WEIGHT_BITS + 8 : 24;
  localparam int SW  = LW + 1;
  localparam logic signed [SW-1:0] DELTA_INIT = {1'b0, {(SW-1){1'b1}}};

  state_t state_r, state_nxt;

  logic signed [LW-1:0] rl_r [MAX_SIZE];
  logic signed [LW-1:0] rl_nxt [MAX_SIZE];
  logic signed [LW-1:0] cl_r [MAX_SIZE];
  logic signed [LW-1:0] cl_nxt [MAX_SIZE];
  logic [IW-1:0] match_r [MAX_SIZE];
  logic [IW-1:0] match_nxt [MAX_SIZE];
  logic [MAX_SIZE-1:0] matched_r, matched_nxt;
  logic [MAX_SIZE-1:0] rv_r, rv_nxt;
  logic [MAX_SIZE-1:0] cv_r, cv_nxt;

  logic [IW-1:0] stk_row_r [MAX_SIZE];
  logic [IW-1:0] stk_row_nxt [MAX_SIZE];
  logic [NW-1:0] stk_next_r [MAX_SIZE];
  logic [NW-1:0] stk_next_nxt [MAX_SIZE];
  logic [IW-1:0] stk_take_r [MAX_SIZE];
  logic [IW-1:0] stk_take_nxt [MAX_SIZE];
  logic [NW-1:0] sp_r, sp_nxt;

  logic [IW-1:0] root_r, root_nxt;
  logic [IW-1:0] bk_r, bk_nxt;
  logic [IW-1:0] cur_r_r, cur_r_nxt;
  logic [IW-1:0] cur_c_r, cur_c_nxt;
  logic [IW-1:0] cur_f_r, cur_f_nxt;

  // scan issue counters and a registered tag that lines up with the RAM read data
  logic [IW-1:0] scan_r_r, scan_r_nxt;
  logic [IW-1:0] scan_c_r, scan_c_nxt;
  logic          iss_r, iss_nxt;
  logic          p_valid_r, p_valid_nxt;
  logic          p_end_r, p_end_nxt;
  logic [IW-1:0] p_row_r, p_row_nxt;
  logic [IW-1:0] p_col_r, p_col_nxt;

  logic signed [SW-1:0] delta_r, delta_nxt;
  logic [IW-1:0]        oc_r, oc_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;

  // combinational helpers
  logic signed [LW-1:0] w_ext;
  logic [NW-1:0]        n_m1;
  logic [IW-1:0]        top_f;
  logic [IW-1:0]        top_row;
  logic [NW-1:0]        top_col;
  logic signed [SW-1:0] lsum;
  logic signed [SW-1:0] slack;
  logic signed [SW-1:0] d_use;
  logic [IW-1:0]        sp_idx;

  assign w_ext   = LW'(signed'(rd_data));
  assign n_m1    = n - NW'(1);
  assign top_f   = IW'(sp_r - NW'(1));
  assign top_row = stk_row_r[top_f];
  assign top_col = stk_next_r[top_f];
  assign sp_idx  = IW'(sp_r);

  // state and storage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      matched_r <= '0;
      rv_r      <= '0;
      cv_r      <= '0;
      sp_r      <= '0;
      iss_r     <= 1'b0;
      p_valid_r <= 1'b0;
      for (int j = 0; j < MAX_SIZE; j++) begin
        rl_r[j] <= '0;
        cl_r[j] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      matched_r <= matched_nxt;
      rv_r      <= rv_nxt;
      cv_r      <= cv_nxt;
      sp_r      <= sp_nxt;
      iss_r     <= iss_nxt;
      p_valid_r <= p_valid_nxt;
      rl_r      <= rl_nxt;
      cl_r      <= cl_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    match_r    <= match_nxt;
    stk_row_r  <= stk_row_nxt;
    stk_next_r <= stk_next_nxt;
    stk_take_r <= stk_take_nxt;
    root_r     <= root_nxt;
    bk_r       <= bk_nxt;
    cur_r_r    <= cur_r_nxt;
    cur_c_r    <= cur_c_nxt;
    cur_f_r    <= cur_f_nxt;
    scan_r_r   <= scan_r_nxt;
    scan_c_r   <= scan_c_nxt;
    p_end_r    <= p_end_nxt;
    p_row_r    <= p_row_nxt;
    p_col_r    <= p_col_nxt;
    delta_r    <= delta_nxt;
    oc_r       <= oc_nxt;
    total_r    <= total_nxt;
  end

  // next state, datapath and RAM read address
  always_comb begin
    state_nxt    = state_r;
    rl_nxt       = rl_r;
    cl_nxt       = cl_r;
    match_nxt    = match_r;
    matched_nxt  = matched_r;
    rv_nxt       = rv_r;
    cv_nxt       = cv_r;
    stk_row_nxt  = stk_row_r;
    stk_next_nxt = stk_next_r;
    stk_take_nxt = stk_take_r;
    sp_nxt       = sp_r;
    root_nxt     = root_r;
    bk_nxt       = bk_r;
    cur_r_nxt    = cur_r_r;
    cur_c_nxt    = cur_c_r;
    cur_f_nxt    = cur_f_r;
    scan_r_nxt   = scan_r_r;
    scan_c_nxt   = scan_c_r;
    iss_nxt      = iss_r;
    p_valid_nxt  = 1'b0;
    p_end_nxt    = 1'b0;
    p_row_nxt    = scan_r_r;
    p_col_nxt    = scan_c_r;
    delta_nxt    = delta_r;
    oc_nxt       = oc_r;
    total_nxt    = total_r;
    rd_addr      = AW'(scan_r_r) * AW'(n) + AW'(scan_c_r);
    res          = '0;
    lsum         = SW'(rl_r[cur_r_r]) + SW'(cl_r[cur_c_r]);
    slack        = SW'(rl_r[p_row_r]) + SW'(cl_r[p_col_r]) - SW'(w_ext);
    d_use        = (delta_r <= 0) ? SW'(1) : delta_r;

    // shared scan issue for the row maxima and slack passes
    if ((state_r == S_INIT || state_r == S_DELTA) && iss_r) begin
      p_valid_nxt = 1'b1;
      if (NW'(scan_c_r) == n_m1) begin
        scan_c_nxt = '0;
        if (NW'(scan_r_r) == n_m1) begin
          iss_nxt   = 1'b0;
          p_end_nxt = 1'b1;
        end else begin
          scan_r_nxt = scan_r_r + IW'(1);
        end
      end else begin
        scan_c_nxt = scan_c_r + IW'(1);
      end
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          matched_nxt = '0;
          for (int j = 0; j < MAX_SIZE; j++) begin
            cl_nxt[j] = '0;
          end
          scan_r_nxt = '0;
          scan_c_nxt = '0;
          iss_nxt    = 1'b1;
          state_nxt  = S_INIT;
        end
      end
      S_INIT: begin
        if (p_valid_r) begin
          if (p_col_r == '0 || w_ext > rl_r[p_row_r]) begin
            rl_nxt[p_row_r] = w_ext;
          end
          if (p_end_r) begin
            root_nxt  = '0;
            state_nxt = S_TRY;
          end
        end
      end
      S_TRY: begin
        rv_nxt             = '0;
        cv_nxt             = '0;
        rv_nxt[root_r]     = 1'b1;
        stk_row_nxt[0]     = root_r;
        stk_next_nxt[0]    = '0;
        sp_nxt             = NW'(1);
        state_nxt          = S_DFS;
      end
      S_DFS: begin
        rd_addr = AW'(top_row) * AW'(n) + AW'(top_col);
        if (sp_r == '0) begin
          delta_nxt  = DELTA_INIT;
          scan_r_nxt = '0;
          scan_c_nxt = '0;
          iss_nxt    = 1'b1;
          state_nxt  = S_DELTA;
        end else if (top_col >= n) begin
          sp_nxt = sp_r - NW'(1);
        end else begin
          stk_next_nxt[top_f] = top_col + NW'(1);
          cur_r_nxt = top_row;
          cur_c_nxt = IW'(top_col);
          cur_f_nxt = top_f;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (lsum != SW'(w_ext) || cv_r[cur_c_r]) begin
          state_nxt = S_DFS;
        end else begin
          cv_nxt[cur_c_r] = 1'b1;
          if (!matched_r[cur_c_r]) begin
            // free column: augmenting path found
            match_nxt[cur_c_r]   = cur_r_r;
            matched_nxt[cur_c_r] = 1'b1;
            if (cur_f_r == '0) begin
              state_nxt = S_NEXT;
            end else begin
              bk_nxt    = cur_f_r - IW'(1);
              state_nxt = S_BACK;
            end
          end else begin
            stk_take_nxt[cur_f_r]   = cur_c_r;
            rv_nxt[match_r[cur_c_r]] = 1'b1;
            stk_row_nxt[sp_idx]     = match_r[cur_c_r];
            stk_next_nxt[sp_idx]    = '0;
            sp_nxt                  = sp_r + NW'(1);
            state_nxt               = S_DFS;
          end
        end
      end
      S_BACK: begin
        match_nxt[stk_take_r[bk_r]] = stk_row_r[bk_r];
        if (bk_r == '0) begin
          state_nxt = S_NEXT;
        end else begin
          bk_nxt = bk_r - IW'(1);
        end
      end
      S_NEXT: begin
        if (NW'(root_r) == n_m1) begin
          oc_nxt    = '0;
          total_nxt = '0;
          state_nxt = S_ORD;
        end else begin
          root_nxt  = root_r + IW'(1);
          state_nxt = S_TRY;
        end
      end
      S_DELTA: begin
        if (p_valid_r) begin
          if (rv_r[p_row_r] && !cv_r[p_col_r] && slack < delta_r) begin
            delta_nxt = slack;
          end
          if (p_end_r) begin
            state_nxt = S_ADJ;
          end
        end
      end
      S_ADJ: begin
        for (int j = 0; j < MAX_SIZE; j++) begin
          if (rv_r[j]) rl_nxt[j] = rl_r[j] - LW'(d_use);
          if (cv_r[j]) cl_nxt[j] = cl_r[j] + LW'(d_use);
        end
        state_nxt = S_TRY;
      end
      S_ORD: begin
        rd_addr = AW'(match_r[oc_r]) * AW'(n) + AW'(oc_r);
        if (res_free) begin
          state_nxt = S_OLD;
        end
      end
      S_OLD: begin
        total_nxt = total_r + TOTAL_W'(w_ext);
        res.valid = 1'b1;
        res.col   = COL_W'(oc_r);
        res.row   = ROW_W'(match_r[oc_r]);
        res.pair  = PAIR_W'(w_ext);
        res.total = total_r + TOTAL_W'(w_ext);
        res.last  = (NW'(oc_r) == n_m1);
        if (NW'(oc_r) == n_m1) begin
          state_nxt = S_IDLE;
        end else begin
          oc_nxt    = oc_r + IW'(1);
          state_nxt = S_ORD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // stack never holds more rows than the matrix has while solving
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> sp_r <= n)
    else $error("search stack deeper than matrix size");

  // every edge test follows an expansion of the stack top
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHK |-> $past(state_r) == S_DFS)
    else $error("edge check without stack expansion");

  // the row on top of the stack is always marked visited
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DFS && sp_r != '0) |-> rv_r[top_row])
    else $error("stacked row not visited");

  // a result is only produced after its read was granted
  assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> ($past(state_r) == S_ORD && $past(res_free)))
    else $error("result issued without free output register");

endmodule

>>> sv/max_weight_assignment_unit.sv
// Maximum-weight perfect assignment (Kuhn-Munkres). Weights arrive row-major
// one per cycle (in_tready high while loading) into a weight RAM; the weight
// with in_tlast starts the solve, during which in_tready is low. The row
// maxima scan, each equality-edge test of the depth-first search and the
// slack scan after each failed search all go through the single RAM read
// port. Then one result per column leaves, held while out_tready is low.
// The next matrix may load while the last result still waits.
// Depends on mwa_pkg, mwa_ram and mwa_ctrl.
module max_weight_assignment_unit #(
  parameter int MAX_SIZE    = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: matrix_size
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] weight
  input  logic        in_tlast,   // last_weight
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [5:0] column_index, [11:6] row_index,
                                  // [27:12] pair_weight, [49:28] total_weight
  output logic        out_tlast   // last_result
);
  import mwa_pkg::*;

  localparam int NW = $clog2(MAX_SIZE+1);
  localparam int AW = $clog2(MAX_SIZE*MAX_SIZE);

  logic [CFG_W-1:0]       cfg_r;
  logic [NW-1:0]          n_use;
  logic [2*NW-1:0]        nn;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic                   busy_r, busy_nxt;
  logic                   in_fire;
  logic                   out_fire;
  logic                   wr_en;
  logic [WEIGHT_BITS-1:0] w_in;
  logic [AW-1:0]          rd_addr;
  logic [WEIGHT_BITS-1:0] rd_data;
  logic                   res_free;
  res_t                   res;
  logic                   ov_r, ov_nxt;
  res_t                   ores_r;

  assign cfg_ready = 1'b1;
  assign in_tready = !busy_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = ov_r && out_tready;
  assign res_free  = !ov_r || out_tready;

  // size in use, clamped to 1..MAX_SIZE
  always_comb begin
    if (cfg_r == '0) n_use = NW'(1);
    else if (cfg_r > CFG_W'(MAX_SIZE)) n_use = NW'(MAX_SIZE);
    else n_use = NW'(cfg_r);
  end
  assign nn = (2*NW)'(n_use) * (2*NW)'(n_use);

  // weight taken from the low WEIGHT_BITS of the field, or the whole field widened when WEIGHT_BITS exceeds 16
  generate
    if (WEIGHT_BITS <= 16) begin : g_w_narrow
      assign w_in = in_tdata[WEIGHT_BITS-1:0];
    end else begin : g_w_wide
      assign w_in = WEIGHT_BITS'(in_tdata);
    end
  endgenerate

  assign wr_en = in_fire && ((POS_W+1)'(pos_r) < (POS_W+1)'(nn));

  // load position, busy flag and output valid
  always_comb begin
    pos_nxt  = pos_r;
    busy_nxt = busy_r;
    ov_nxt   = ov_r;
    if (in_fire) begin
      if (in_tlast) begin
        pos_nxt  = '0;
        busy_nxt = 1'b1;
      end else if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
    if (out_fire) ov_nxt = 1'b0;
    if (res.valid) begin
      ov_nxt = 1'b1;
      if (res.last) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r  <= CFG_W'(16);
      pos_r  <= '0;
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) cfg_r <= cfg_data;
      pos_r  <= pos_nxt;
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (res.valid) ores_r <= res;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'b0, ores_r.total, ores_r.pair, ores_r.row, ores_r.col};
  assign out_tlast  = ores_r.last;

  mwa_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_SIZE*MAX_SIZE)
  ) u_wram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(pos_r)),
    .wdata (w_in),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mwa_ctrl #(
    .MAX_SIZE    (MAX_SIZE),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire && in_tlast),
    .n        (n_use),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .res_free (res_free),
    .res      (res)
  );

endmodule
